// ----- src/growing_degree_day_accumulator_assert.svh -----
// Assertion macros for the growing degree day accumulator.
`ifndef GROWING_DEGREE_DAY_ACCUMULATOR_ASSERT_SVH
`define GROWING_DEGREE_DAY_ACCUMULATOR_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define GDDA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked on every edge, reset included.
`define GDDA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GDDA_ASSERT(lbl, clk, rst_n, prop, msg)
`define GDDA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ----- src/gdda_pkg.sv -----
// Package with types and constants of the growing degree day accumulator.
`timescale 1ns / 1ps

package gdda_pkg;

  // Default widths of the temperature codes and the accumulator
  localparam int TEMP_WIDTH_DEF  = 16;
  localparam int ACCUM_WIDTH_DEF = 32;

  // Fixed field widths
  localparam int BASE_WIDTH = 16;
  localparam int FRAC_WIDTH = 16;
  localparam int OP_WIDTH   = 2;

  // Base temperature after reset, hundredths of a degree
  localparam logic signed [BASE_WIDTH-1:0] BASE_RESET = 16'sd1000;

  // Operation codes carried on in_tuser
  typedef enum logic [OP_WIDTH-1:0] {
    OP_SAMPLE   = 2'd0,
    OP_COMMIT   = 2'd1,
    OP_FRACTION = 2'd2,
    OP_CLEAR    = 2'd3
  } op_t;

endpackage

// ----- src/growing_degree_day_accumulator.sv -----
// Growing degree day accumulator: average method plus fractional samples.
`timescale 1ns / 1ps
`include "growing_degree_day_accumulator_assert.svh"

// Takes one transaction per clock while the result side is not stalled, and
// returns one result transaction for each: an accepted transaction is first
// loaded into the input register, then compare, multiply and saturating add
// run into the state registers, which also serve as the result register. While
// a result waits on out_tready, one more transaction can still be taken into
// the input register. The user must write base_temperature through
// cfg_wen/cfg_wdata only while no transaction is in flight; the block does not
// enforce this. base_temperature resets to 10.00 degrees.
module growing_degree_day_accumulator #(
  parameter int TEMP_WIDTH  = gdda_pkg::TEMP_WIDTH_DEF,
  parameter int ACCUM_WIDTH = gdda_pkg::ACCUM_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  // Configuration: base_temperature
  input  logic                                            cfg_wen,
  input  logic [gdda_pkg::BASE_WIDTH-1:0]                 cfg_wdata,
  // Input stream
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // tdata: temperature, interval_fraction (low bit first), zero padded
  input  logic [((TEMP_WIDTH+gdda_pkg::FRAC_WIDTH+7)/8)*8-1:0] in_tdata,
  // tuser: operation
  input  logic [gdda_pkg::OP_WIDTH-1:0]                   in_tuser,
  // Result stream
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // tdata: accumulated_degree_days, day_open (low bit first), zero padded
  output logic [((ACCUM_WIDTH+1+7)/8)*8-1:0]              out_tdata
);

  import gdda_pkg::*;

  localparam int EXT_W      = ((TEMP_WIDTH > BASE_WIDTH) ? TEMP_WIDTH : BASE_WIDTH) + 1;
  localparam int ADD_W      = EXT_W - 1;
  localparam int SUM_W      = ((ACCUM_WIDTH > ADD_W) ? ACCUM_WIDTH : ADD_W) + 1;
  localparam int OUT_DATA_W = ((ACCUM_WIDTH + 1 + 7) / 8) * 8;

  // Input register
  logic                         s1_valid_r;
  op_t                          s1_op_r;
  logic signed [TEMP_WIDTH-1:0] s1_temp_r;
  logic [FRAC_WIDTH-1:0]        s1_frac_r;

  // State / result registers
  logic [ACCUM_WIDTH-1:0]       acc_r, acc_nxt;
  logic signed [TEMP_WIDTH-1:0] day_max_r, day_max_nxt;
  logic signed [TEMP_WIDTH-1:0] day_min_r, day_min_nxt;
  logic                         day_valid_r, day_valid_nxt;
  logic                         out_valid_r;
  logic signed [BASE_WIDTH-1:0] base_r;

  logic                         adv;
  logic signed [TEMP_WIDTH:0]   mm_sum;
  logic signed [TEMP_WIDTH-1:0] half;
  logic signed [EXT_W-1:0]      base_ext;
  logic signed [EXT_W-1:0]      commit_diff;
  logic signed [EXT_W-1:0]      frac_diff;
  logic [ADD_W+FRAC_WIDTH-1:0]  frac_prod;
  logic [ADD_W-1:0]             addend;
  logic [SUM_W-1:0]             acc_sum;
  logic [ACCUM_WIDTH-1:0]       acc_added;

  // Handshake: the input register moves on when the result slot is free
  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-ACCUM_WIDTH-1){1'b0}}, day_valid_r, acc_r};

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_op_r   <= op_t'(in_tuser);
      s1_temp_r <= in_tdata[TEMP_WIDTH-1:0];
      s1_frac_r <= in_tdata[TEMP_WIDTH+FRAC_WIDTH-1:TEMP_WIDTH];
    end
  end

  // Base temperature register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
    end else if (cfg_wen) begin
      base_r <= cfg_wdata;
    end
  end

  // Day average (floor) and the differences against the base
  assign base_ext    = {{(EXT_W-BASE_WIDTH){base_r[BASE_WIDTH-1]}}, base_r};
  assign mm_sum      = {day_max_r[TEMP_WIDTH-1], day_max_r} +
                       {day_min_r[TEMP_WIDTH-1], day_min_r};
  assign half        = mm_sum[TEMP_WIDTH:1];
  assign commit_diff = {{(EXT_W-TEMP_WIDTH){half[TEMP_WIDTH-1]}}, half} - base_ext;
  assign frac_diff   = {{(EXT_W-TEMP_WIDTH){s1_temp_r[TEMP_WIDTH-1]}}, s1_temp_r} - base_ext;
  assign frac_prod   = frac_diff[ADD_W-1:0] * s1_frac_r;

  // Addend selection; only positive differences count
  always_comb begin
    addend = '0;
    case (s1_op_r)
      OP_COMMIT: begin
        if (day_valid_r && commit_diff > 0) addend = commit_diff[ADD_W-1:0];
      end
      OP_FRACTION: begin
        if (frac_diff > 0) addend = frac_prod[ADD_W+FRAC_WIDTH-1:FRAC_WIDTH];
      end
      default: addend = '0;
    endcase
  end

  // Saturating add
  assign acc_sum   = {{(SUM_W-ACCUM_WIDTH){1'b0}}, acc_r} + {{(SUM_W-ADD_W){1'b0}}, addend};
  assign acc_added = (acc_sum > {{(SUM_W-ACCUM_WIDTH){1'b0}}, {ACCUM_WIDTH{1'b1}}}) ?
                     {ACCUM_WIDTH{1'b1}} : acc_sum[ACCUM_WIDTH-1:0];

  // Next state per operation
  always_comb begin
    acc_nxt       = acc_r;
    day_max_nxt   = day_max_r;
    day_min_nxt   = day_min_r;
    day_valid_nxt = day_valid_r;
    case (s1_op_r)
      OP_SAMPLE: begin
        day_valid_nxt = 1'b1;
        if (!day_valid_r || s1_temp_r > day_max_r) day_max_nxt = s1_temp_r;
        if (!day_valid_r || s1_temp_r < day_min_r) day_min_nxt = s1_temp_r;
      end
      OP_COMMIT: begin
        if (day_valid_r) begin
          acc_nxt       = acc_added;
          day_valid_nxt = 1'b0;
          day_max_nxt   = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
          day_min_nxt   = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
        end
      end
      OP_FRACTION: begin
        acc_nxt = acc_added;
      end
      OP_CLEAR: begin
        acc_nxt       = '0;
        day_valid_nxt = 1'b0;
        day_max_nxt   = {1'b1, {(TEMP_WIDTH-1){1'b0}}};
        day_min_nxt   = {1'b0, {(TEMP_WIDTH-1){1'b1}}};
      end
      default: acc_nxt = acc_r;
    endcase
  end

  // State and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      day_max_r   <= {1'b1, {(TEMP_WIDTH-1){1'b0}}};
      day_min_r   <= {1'b0, {(TEMP_WIDTH-1){1'b1}}};
      day_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv) begin
        acc_r       <= acc_nxt;
        day_max_r   <= day_max_nxt;
        day_min_r   <= day_min_nxt;
        day_valid_r <= day_valid_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Checks
  `GDDA_ASSERT(a_stall_blocks_input, clk, rst_n,
    s1_valid_r && out_valid_r && !out_tready |-> !in_tready, "input taken while stalled")
  `GDDA_ASSERT(a_acc_monotonic, clk, rst_n,
    adv && s1_op_r != OP_CLEAR |=> acc_r >= $past(acc_r), "accumulator decreased")
  `GDDA_ASSERT(a_clear_zeroes, clk, rst_n,
    adv && s1_op_r == OP_CLEAR |=> acc_r == '0 && !day_valid_r, "clear not applied")
  `GDDA_ASSERT(a_day_order, clk, rst_n,
    day_valid_r |-> day_max_r >= day_min_r, "day maximum below minimum")
  `GDDA_ASSERT_ALWAYS(a_reset_idle, clk,
    !rst_n |=> !out_valid_r && !s1_valid_r, "not idle after reset")

endmodule
